// ===== hdl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and sizes of the sparse matrix transpose block.
// ----------------------------------------------------------------------------
`default_nettype none
package sct_pkg;
	localparam int MAX_ROWS = 1024;
	localparam int MAX_COLS = 1024;
	localparam int MAX_NNZ  = 4096;
	localparam int IDX_W    = 10;
	localparam int PTR_W    = 13;
	localparam int VAL_W    = 64;
	localparam int LIM_W    = 11;
	localparam int COL_AW   = $clog2(MAX_COLS);
	localparam int NNZ_AW   = $clog2(MAX_NNZ);

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_RDPTR = 2'd1;
	localparam logic [1:0] REQ_RDENT = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_COL  = 3'd1;
	localparam logic [2:0] ST_BAD_ROW  = 3'd2;
	localparam logic [2:0] ST_ORDER    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_RD_INVAL = 3'd5;

	localparam logic [1:0] CFG_NUM_COLS = 2'd0;
	localparam logic [1:0] CFG_NUM_ROWS = 2'd1;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
		logic [VAL_W-1:0] entry_value;
		logic             last_entry;
		logic [PTR_W-1:0] read_index;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [PTR_W-1:0] pointer_value;
		logic [IDX_W-1:0] out_row;
		logic [VAL_W-1:0] value_out;
		logic             ready_res;
	} res_t;

	typedef struct packed {
		logic cnt_rd_col;
		logic cnt_rd_ridx;
		logic cnt_rd_idx;
		logic cnt_wr_zero;
		logic cnt_wr_inc;
		logic cnt_wr_sum;
		logic in_rd;
		logic cur_rd;
		logic sc_wr;
		logic out_rd;
		logic idx_clr;
		logic idx_inc;
		logic sum_clr;
		logic res_load;
		logic res_ptr_rd;
		logic res_ptr_last;
		logic res_ent;
		logic fire;
		logic set_done;
		logic clr_regs;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       last;
		logic       done;
		logic       ld_ok;
		logic       rd_ok;
		logic       ptr_top;
		logic       idx_col_end;
		logic       idx_at_count;
	} sts_t;
endpackage
`default_nettype wire

// ===== hdl/sct_ram.sv =====
// ----------------------------------------------------------------------------
// sct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sct_ctrl.sv =====
// ----------------------------------------------------------------------------
// sct_ctrl
// Sequencer for load, read, clear, prefix sum and scatter passes.
// ----------------------------------------------------------------------------
`default_nettype none
module sct_ctrl import sct_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output      logic busy,
	input  wire sts_t sts,
	output      cmd_t cmd
);
	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_EXEC   = 4'd2;
	localparam logic [3:0] S_INC    = 4'd3;
	localparam logic [3:0] S_RDP    = 4'd4;
	localparam logic [3:0] S_RDE    = 4'd5;
	localparam logic [3:0] S_PRE_RD = 4'd6;
	localparam logic [3:0] S_PRE_WR = 4'd7;
	localparam logic [3:0] S_SC_RD  = 4'd8;
	localparam logic [3:0] S_SC_CUR = 4'd9;
	localparam logic [3:0] S_SC_WR  = 4'd10;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.cnt_wr_zero = 1'b1;
				cmd.idx_inc     = 1'b1;
				if (sts.idx_col_end) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.res_load = 1'b1;
				case (sts.req_type)
					REQ_LOAD: begin
						if (sts.done) begin
							cmd.fire = 1'b1;
							state_d  = S_IDLE;
						end else if (sts.ld_ok) begin
							cmd.cnt_rd_col = 1'b1;
							state_d        = S_INC;
						end else if (sts.last) begin
							cmd.idx_clr = 1'b1;
							cmd.sum_clr = 1'b1;
							state_d     = S_PRE_RD;
						end else begin
							cmd.fire = 1'b1;
							state_d  = S_IDLE;
						end
					end
					REQ_RDPTR: begin
						if (!sts.rd_ok) begin
							cmd.fire = 1'b1;
							state_d  = S_IDLE;
						end else if (sts.ptr_top) begin
							cmd.res_ptr_last = 1'b1;
							cmd.fire         = 1'b1;
							state_d          = S_IDLE;
						end else begin
							cmd.cnt_rd_ridx = 1'b1;
							state_d         = S_RDP;
						end
					end
					REQ_RDENT: begin
						if (!sts.rd_ok) begin
							cmd.fire = 1'b1;
							state_d  = S_IDLE;
						end else begin
							cmd.out_rd = 1'b1;
							state_d    = S_RDE;
						end
					end
					default: begin
						cmd.clr_regs = 1'b1;
						cmd.fire     = 1'b1;
						cmd.idx_clr  = 1'b1;
						state_d      = S_CLR;
					end
				endcase
			end
			S_INC: begin
				cmd.cnt_wr_inc = 1'b1;
				if (sts.last) begin
					cmd.idx_clr = 1'b1;
					cmd.sum_clr = 1'b1;
					state_d     = S_PRE_RD;
				end else begin
					cmd.fire = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_RDP: begin
				cmd.res_ptr_rd = 1'b1;
				cmd.fire       = 1'b1;
				state_d        = S_IDLE;
			end
			S_RDE: begin
				cmd.res_ent = 1'b1;
				cmd.fire    = 1'b1;
				state_d     = S_IDLE;
			end
			S_PRE_RD: begin
				cmd.cnt_rd_idx = 1'b1;
				state_d        = S_PRE_WR;
			end
			S_PRE_WR: begin
				cmd.cnt_wr_sum = 1'b1;
				if (sts.idx_col_end) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_SC_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_PRE_RD;
				end
			end
			S_SC_RD: begin
				if (sts.idx_at_count) begin
					cmd.set_done = 1'b1;
					cmd.fire     = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.in_rd = 1'b1;
					state_d   = S_SC_CUR;
				end
			end
			S_SC_CUR: begin
				cmd.cur_rd = 1'b1;
				state_d    = S_SC_WR;
			end
			S_SC_WR: begin
				cmd.sc_wr   = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_SC_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sct_dp.sv =====
// ----------------------------------------------------------------------------
// sct_dp
// Datapath: entry, count/pointer, cursor and output stores, checks, result.
// ----------------------------------------------------------------------------
`default_nettype none
module sct_dp import sct_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire req_t             req,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [LIM_W-1:0] cfg_data,
	input  wire cmd_t             cmd,
	output      sts_t             sts,
	output      logic             res_valid,
	output      res_t             res
);
	localparam int IN_W  = 2 * IDX_W + VAL_W;
	localparam int OUT_W = IDX_W + VAL_W;

	req_t             req_q;
	logic [LIM_W-1:0] num_cols_q, num_rows_q;
	logic [PTR_W-1:0] entry_cnt_q, idx_q, sum_q, ptr_last_q;
	logic [IDX_W-1:0] prev_row_q;
	logic             done_q, res_valid_q;
	res_t             res_q;

	logic [LIM_W-1:0] col_lim, row_lim;
	logic [2:0]       ld_status;
	logic             rd_ok;

	logic              cnt_we, cnt_re, cur_we;
	logic [COL_AW-1:0] cnt_waddr, cnt_raddr, cur_waddr;
	logic [PTR_W-1:0]  cnt_wdata, cnt_rdata, cur_wdata, cur_rdata;
	logic [IN_W-1:0]   in_rdata;
	logic [OUT_W-1:0]  out_rdata;
	logic [IDX_W-1:0]  sc_row, sc_col;
	logic [VAL_W-1:0]  sc_val;

	assign col_lim = (num_cols_q > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS) : num_cols_q;
	assign row_lim = (num_rows_q > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : num_rows_q;
	assign {sc_row, sc_col, sc_val} = in_rdata;

	always_comb begin
		if ({1'b0, req_q.col_index} >= col_lim)      ld_status = ST_BAD_COL;
		else if ({1'b0, req_q.row_index} >= row_lim) ld_status = ST_BAD_ROW;
		else if (req_q.row_index < prev_row_q)       ld_status = ST_ORDER;
		else if (entry_cnt_q >= PTR_W'(MAX_NNZ))     ld_status = ST_FULL;
		else                                         ld_status = ST_OK;
	end

	always_comb begin
		if (req_q.req_type == REQ_RDPTR) begin
			rd_ok = done_q && (req_q.read_index <= PTR_W'(col_lim));
		end else begin
			rd_ok = done_q && (req_q.read_index < entry_cnt_q);
		end
	end

	assign sts.req_type     = req_q.req_type;
	assign sts.last         = req_q.last_entry;
	assign sts.done         = done_q;
	assign sts.ld_ok        = (ld_status == ST_OK);
	assign sts.rd_ok        = rd_ok;
	assign sts.ptr_top      = (req_q.read_index == PTR_W'(MAX_COLS));
	assign sts.idx_col_end  = (idx_q == PTR_W'(MAX_COLS - 1));
	assign sts.idx_at_count = (idx_q == entry_cnt_q);

	always_comb begin
		cnt_re    = cmd.cnt_rd_col | cmd.cnt_rd_ridx | cmd.cnt_rd_idx;
		cnt_raddr = idx_q[COL_AW-1:0];
		if (cmd.cnt_rd_col)  cnt_raddr = req_q.col_index[COL_AW-1:0];
		if (cmd.cnt_rd_ridx) cnt_raddr = req_q.read_index[COL_AW-1:0];
		cnt_we    = cmd.cnt_wr_zero | cmd.cnt_wr_inc | cmd.cnt_wr_sum;
		cnt_waddr = cmd.cnt_wr_inc ? req_q.col_index[COL_AW-1:0] : idx_q[COL_AW-1:0];
		cnt_wdata = '0;
		if (cmd.cnt_wr_inc) cnt_wdata = cnt_rdata + PTR_W'(1);
		if (cmd.cnt_wr_sum) cnt_wdata = sum_q;
		cur_we    = cmd.cnt_wr_sum | (cmd.sc_wr & ~cur_rdata[PTR_W-1]);
		cur_waddr = cmd.sc_wr ? sc_col[COL_AW-1:0] : idx_q[COL_AW-1:0];
		cur_wdata = cmd.sc_wr ? cur_rdata + PTR_W'(1) : sum_q;
	end

	sct_ram #(.WIDTH(PTR_W), .DEPTH(MAX_COLS)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	sct_ram #(.WIDTH(PTR_W), .DEPTH(MAX_COLS)) u_cur (
		.clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
		.re(cmd.cur_rd), .raddr(sc_col[COL_AW-1:0]), .rdata(cur_rdata)
	);

	sct_ram #(.WIDTH(IN_W), .DEPTH(MAX_NNZ)) u_in (
		.clk(clk), .we(cmd.cnt_wr_inc), .waddr(entry_cnt_q[NNZ_AW-1:0]),
		.wdata({req_q.row_index, req_q.col_index, req_q.entry_value}),
		.re(cmd.in_rd), .raddr(idx_q[NNZ_AW-1:0]), .rdata(in_rdata)
	);

	sct_ram #(.WIDTH(OUT_W), .DEPTH(MAX_NNZ)) u_out (
		.clk(clk), .we(cmd.sc_wr & ~cur_rdata[PTR_W-1]),
		.waddr(cur_rdata[NNZ_AW-1:0]), .wdata({sc_row, sc_val}),
		.re(cmd.out_rd), .raddr(req_q.read_index[NNZ_AW-1:0]), .rdata(out_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.cnt_wr_sum) begin
			sum_q      <= sum_q + cnt_rdata;
			ptr_last_q <= sum_q + cnt_rdata;
		end
		if (cmd.clr_regs) ptr_last_q <= '0;
		if (cmd.res_load) begin
			res_q.status        <= (req_q.req_type == REQ_LOAD) ?
			                       (done_q ? ST_FULL : ld_status) :
			                       (req_q.req_type == REQ_CLEAR) ? ST_OK :
			                       (rd_ok ? ST_OK : ST_RD_INVAL);
			res_q.pointer_value <= cmd.res_ptr_last ? ptr_last_q : '0;
			res_q.out_row       <= '0;
			res_q.value_out     <= '0;
		end
		if (cmd.res_ptr_rd)   res_q.pointer_value <= cnt_rdata;
		if (cmd.res_ent)      {res_q.out_row, res_q.value_out} <= out_rdata;
		if (cmd.fire)         res_q.ready_res <= cmd.set_done | (done_q & ~cmd.clr_regs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q  <= LIM_W'(1024);
			num_rows_q  <= LIM_W'(1024);
			entry_cnt_q <= '0;
			prev_row_q  <= '0;
			done_q      <= 1'b0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_NUM_COLS) num_cols_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_NUM_ROWS) num_rows_q <= cfg_data;
			if (cmd.cnt_wr_inc) begin
				entry_cnt_q <= entry_cnt_q + PTR_W'(1);
				prev_row_q  <= req_q.row_index;
			end
			if (cmd.clr_regs) begin
				entry_cnt_q <= '0;
				prev_row_q  <= '0;
				done_q      <= 1'b0;
			end
			if (cmd.set_done) done_q <= 1'b1;
			if (cmd.idx_clr)      idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + PTR_W'(1);
			res_valid_q <= cmd.fire;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= PTR_W'(MAX_NNZ))
		else $error("entry count beyond store depth");
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_done |=> res_valid_q && res_q.ready_res)
		else $error("finish result lacks ready flag");
	a_clr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_regs |=> entry_cnt_q == '0 && !done_q)
		else $error("clear left stored state");
`endif
endmodule
`default_nettype wire

// ===== hdl/sparse_csr_transpose.sv =====
// ----------------------------------------------------------------------------
// sparse_csr_transpose
// Transpose of a compressed-row sparse matrix by counting sort.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; every request
// gives exactly one result beat, shown for one cycle with res_valid high.
// The receiver cannot stall: res is valid only in the res_valid cycle.
// Loads, reads and clears raise res_valid from S_EXEC, or from S_INC, S_RDP or
// S_RDE for a stored load and an in-range pointer (below 1024) or entry read;
// busy drops with it, but after a clear only once the sweep ends; no new request is taken while busy.
// The load marked last runs the prefix sum (S_PRE_RD, S_PRE_WR per column
// of the count store), then the scatter (S_SC_RD, S_SC_CUR, S_SC_WR per entry),
// both paced by the single read port of each store; its result follows.
// Reset and a clear request both sweep all of the count store to zero,
// with busy high; configuration writes are taken at any time (cfg_ready
// is tied high) and must only be issued while the block is idle.
// Register 0 is num_cols, register 1 is num_rows; both reset to 1024.
// ----------------------------------------------------------------------------
`default_nettype none
module sparse_csr_transpose import sct_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire req_t             req,
	output      logic             res_valid,
	output      res_t             res,
	input  wire logic             cfg_valid,
	output      logic             cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [LIM_W-1:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	sct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	sct_dp u_dp (
		.clk(clk), .arst_n(arst_n), .accept(start & ~busy), .req(req),
		.cfg_we(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .res_valid(res_valid), .res(res)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");
	a_res_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid)
		else $error("back to back result beats");
	a_res_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(busy))
		else $error("result beat without a request in work");
`endif
endmodule
`default_nettype wire
